### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/gbc_pkg.sv
package gbc_pkg;

  localparam int PosW   = 16;
  localparam int CfgW   = 16;
  localparam int IdxW   = 3;
  localparam int GammaW = 16;
  localparam int BcW    = 14;
  localparam int BalW   = 16;
  localparam int OutW   = 16;
  localparam int MantW  = 31;
  localparam int FracW  = 16;
  localparam int NegW   = 21;
  localparam int DivW   = 33;
  localparam int RemW   = 16;
  localparam int PowW   = 31;
  localparam int TblW   = 30;

  typedef enum logic [IdxW-1:0] {
    REG_GAMMA      = 3'd0,
    REG_BRIGHTNESS = 3'd1,
    REG_CONTRAST   = 3'd2,
    REG_BAL_RED    = 3'd3,
    REG_BAL_GREEN  = 3'd4,
    REG_BAL_BLUE   = 3'd5,
    REG_MIN_OUT    = 3'd6,
    REG_MAX_OUT    = 3'd7
  } gbc_reg_t;

  typedef struct packed {
    logic last;
    logic zero;
  } gbc_tag_t;

  typedef logic [FracW-1:0][TblW-1:0] exp_tbl_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] b;
    res = '0;
    rem = v;
    for (int j = 0; j < 32; j++) begin
      b = 64'd1 << (62 - 2 * j);
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Entry i is 2^(-2^-(i+1)), Q0.30, the floor square root of the one before.
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t tbl;
    logic [63:0] t;
    t = isqrt64(64'd1 << 59);
    tbl[0] = t[TblW-1:0];
    for (int i = 1; i < FracW; i++) begin
      t = isqrt64(t << 30);
      tbl[i] = t[TblW-1:0];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t ExpTbl = build_exp_tbl();

endpackage

### design/gbc_log2.sv
module gbc_log2 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [gbc_pkg::PosW-1:0]  position,
  input  gbc_pkg::gbc_tag_t         in_tag,
  output logic                      out_valid,
  output logic [gbc_pkg::NegW-1:0]  neg,
  output gbc_pkg::gbc_tag_t         out_tag
);
  import gbc_pkg::*;

  localparam int Steps = FracW;

  logic [3:0]         lead;
  logic [PosW-1:0]    norm;
  logic [Steps:0]     vld;
  logic [MantW-1:0]   mant [0:Steps];
  logic [3:0]         kk   [0:Steps];
  logic [FracW-1:0]   frac [0:Steps];
  gbc_tag_t           tag  [0:Steps];
  logic [2*MantW-1:0] sq   [1:Steps];
  logic [MantW:0]     sqh  [1:Steps];

  always_comb begin
    lead = '0;
    for (int b = 0; b < PosW; b++) begin
      if (position[b]) begin
        lead = 4'(b);
      end
    end
    norm = position << (4'd15 - lead);
  end

  always_comb begin
    for (int s = 1; s <= Steps; s++) begin
      sq[s]  = mant[s-1] * mant[s-1];
      sqh[s] = sq[s][2*MantW-1:MantW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Steps-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant[0] <= {norm, 15'b0};
      kk[0]   <= lead;
      frac[0] <= '0;
      tag[0]  <= in_tag;
      for (int s = 1; s <= Steps; s++) begin
        mant[s] <= sqh[s][MantW] ? sqh[s][MantW:1] : sqh[s][MantW-1:0];
        frac[s] <= frac[s-1] | (sqh[s][MantW] ? (FracW'(1) << (FracW - s)) : '0);
        kk[s]   <= kk[s-1];
        tag[s]  <= tag[s-1];
      end
    end
  end

  assign out_valid = vld[Steps];
  assign out_tag   = tag[Steps];
  assign neg = (NegW'(5'd16 - {1'b0, kk[Steps]}) << 16) - NegW'(frac[Steps]);

endmodule

### design/gbc_div.sv
module gbc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [gbc_pkg::GammaW-1:0] gamma,
  input  logic                       in_valid,
  input  logic [gbc_pkg::NegW-1:0]   neg,
  input  gbc_pkg::gbc_tag_t          in_tag,
  output logic                       out_valid,
  output logic [gbc_pkg::DivW-1:0]   quo,
  output gbc_pkg::gbc_tag_t          out_tag
);
  import gbc_pkg::*;

  localparam int Steps = DivW;

  logic [GammaW-1:0] g_eff;
  logic [Steps:0]    vld;
  logic [RemW-1:0]   rem  [0:Steps];
  logic [DivW-1:0]   num  [0:Steps];
  logic [DivW-1:0]   qt   [0:Steps];
  gbc_tag_t          tag  [0:Steps];
  logic [RemW:0]     sh   [1:Steps];
  logic              take [1:Steps];

  assign g_eff = (gamma == '0) ? GammaW'(1) : gamma;

  always_comb begin
    for (int s = 1; s <= Steps; s++) begin
      sh[s]   = {rem[s-1], num[s-1][DivW-1]};
      take[s] = (sh[s] >= {1'b0, g_eff});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Steps-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      num[0] <= {neg, 12'b0};
      qt[0]  <= '0;
      tag[0] <= in_tag;
      for (int s = 1; s <= Steps; s++) begin
        rem[s] <= take[s] ? RemW'(sh[s] - {1'b0, g_eff}) : sh[s][RemW-1:0];
        num[s] <= num[s-1] << 1;
        qt[s]  <= {qt[s-1][DivW-2:0], take[s]};
        tag[s] <= tag[s-1];
      end
    end
  end

  assign out_valid = vld[Steps];
  assign quo       = qt[Steps];
  assign out_tag   = tag[Steps];

endmodule

### design/gbc_exp2.sv
module gbc_exp2 (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [gbc_pkg::DivW-1:0] quo,
  input  gbc_pkg::gbc_tag_t        in_tag,
  output logic                     out_valid,
  output logic [gbc_pkg::PowW-1:0] pow,
  output gbc_pkg::gbc_tag_t        out_tag
);
  import gbc_pkg::*;

  localparam int Steps = FracW;
  localparam int HiW   = DivW - FracW;

  logic [HiW-1:0]        hi;
  logic [Steps+1:0]      vld;
  logic [PowW-1:0]       r    [0:Steps];
  logic [FracW-1:0]      f    [0:Steps];
  logic [4:0]            nsh  [0:Steps];
  logic                  zf   [0:Steps];
  gbc_tag_t              tag  [0:Steps];
  logic [PowW+TblW-1:0]  prod [1:Steps];
  logic [PowW-1:0]       pow_q;
  gbc_tag_t              tag_q;

  assign hi = quo[DivW-1:FracW];

  always_comb begin
    for (int s = 1; s <= Steps; s++) begin
      prod[s] = r[s-1] * ExpTbl[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Steps:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= PowW'(1) << 30;
      f[0]   <= quo[FracW-1:0];
      nsh[0] <= hi[4:0];
      zf[0]  <= in_tag.zero | (hi >= HiW'(31));
      tag[0] <= in_tag;
      for (int s = 1; s <= Steps; s++) begin
        r[s]   <= f[s-1][FracW-s] ? prod[s][PowW+TblW-1:TblW] : r[s-1];
        f[s]   <= f[s-1];
        nsh[s] <= nsh[s-1];
        zf[s]  <= zf[s-1];
        tag[s] <= tag[s-1];
      end
      pow_q <= zf[Steps] ? '0 : (r[Steps] >> nsh[Steps]);
      tag_q <= tag[Steps];
    end
  end

  assign out_valid = vld[Steps+1];
  assign pow       = pow_q;
  assign out_tag   = tag_q;

endmodule

### design/gbc_shape.sv
module gbc_shape (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [gbc_pkg::BcW-1:0]    brightness,
  input  logic [gbc_pkg::BcW-1:0]    contrast,
  input  logic [gbc_pkg::BalW-1:0]   balance_red,
  input  logic [gbc_pkg::BalW-1:0]   balance_green,
  input  logic [gbc_pkg::BalW-1:0]   balance_blue,
  input  logic [gbc_pkg::OutW-1:0]   min_out,
  input  logic [gbc_pkg::OutW-1:0]   max_out,
  input  logic                       in_valid,
  input  logic [gbc_pkg::PowW-1:0]   pow,
  input  gbc_pkg::gbc_tag_t          in_tag,
  output logic                       out_valid,
  output logic [gbc_pkg::OutW-1:0]   red,
  output logic [gbc_pkg::OutW-1:0]   green,
  output logic [gbc_pkg::OutW-1:0]   blue,
  output logic                       last_out
);
  import gbc_pkg::*;

  localparam int CtW  = BcW + 1;
  localparam int PaW  = CtW + PowW;
  localparam int C30W = 36;
  localparam int SpW  = OutW + 1;
  localparam int M2W  = 54;
  localparam int V16W = M2W - 14;
  localparam int PW   = V16W + BalW + 1;
  localparam int XW   = PW - 30;

  logic [5:0]                vld;
  logic [CtW-1:0]            ctp;
  logic signed [CtW-1:0]     diff;
  logic signed [SpW-1:0]     span;
  logic signed [M2W-1:0]     mn_sh;
  logic signed [XW-1:0]      mn_x;
  logic signed [XW-1:0]      mx_x;

  logic [PaW-1:0]            pa;
  logic                      last_a;
  logic signed [C30W-1:0]    c30;
  logic                      last_b;
  logic signed [M2W-1:0]     m2;
  logic                      last_c;
  logic signed [V16W-1:0]    v16;
  logic                      last_d;
  logic signed [M2W-1:0]     sum_d;
  logic signed [PW-1:0]      pe   [0:2];
  logic                      last_e;
  logic [BalW-1:0]           bal  [0:2];
  logic signed [PW-1:0]      rnd  [0:2];
  logic signed [XW-1:0]      xv   [0:2];
  logic [OutW-1:0]           cl   [0:2];

  assign ctp   = {1'b0, contrast} + CtW'(4096);
  assign diff  = $signed({1'b0, brightness}) - $signed({1'b0, contrast});
  assign span  = $signed({1'b0, max_out}) - $signed({1'b0, min_out});
  assign mn_sh = $signed({{(M2W-OutW){1'b0}}, min_out}) <<< 30;
  assign mn_x  = $signed({{(XW-OutW){1'b0}}, min_out});
  assign mx_x  = $signed({{(XW-OutW){1'b0}}, max_out});
  assign sum_d = m2 + mn_sh;
  assign bal[0] = balance_red;
  assign bal[1] = balance_green;
  assign bal[2] = balance_blue;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rnd[ch] = pe[ch] + (PW'(1) <<< 29);
      xv[ch]  = rnd[ch][PW-1:30];
      if (xv[ch] < mn_x) begin
        cl[ch] = min_out;
      end else if (xv[ch] > mx_x) begin
        cl[ch] = max_out;
      end else begin
        cl[ch] = xv[ch][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa     <= ctp * pow;
      last_a <= in_tag.last;
      c30    <= $signed({{(C30W-(PaW-13)){1'b0}}, pa[PaW-1:13]})
              + ($signed({{(C30W-CtW){diff[CtW-1]}}, diff}) <<< 16);
      last_b <= last_a;
      m2     <= c30 * span;
      last_c <= last_b;
      v16    <= sum_d[M2W-1:14];
      last_d <= last_c;
      for (int ch = 0; ch < 3; ch++) begin
        pe[ch] <= v16 * $signed({1'b0, bal[ch]});
      end
      last_e   <= last_d;
      red      <= cl[0];
      green    <= cl[1];
      blue     <= cl[2];
      last_out <= last_e;
    end
  end

  assign out_valid = vld[5];

endmodule

### design/gamma_brightness_contrast_curve_core.sv
// Gamma, brightness and contrast curve generator.
// Input channel: in_valid/in_ready carry one control position (unsigned Q0.16)
// and a last_point flag per transfer. Output channel: out_valid/out_ready carry
// the red, green and blue curve values (Q0.16, clamped to min_out..max_out)
// and last_out, a copy of the flag.
// Configuration: cfg_write with cfg_index and cfg_data writes one register; the
// user must change registers only while no points are in flight; it is
// not enforced by the block. From an input transfer to its result the pipeline
// has 17 stages of log2 by repeated squaring, 34 stages of restoring division by
// gamma, 18 stages of exp2 products and shift, and 6 stages of shaping, range
// mapping, balance and clamp, the last being the output register.
// Throughput is one point per cycle when not stalled. The whole pipeline
// advances together; while a result waits on out_ready the pipeline holds and
// in_ready is low, and nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: gamma 1.0,
// brightness 1.0, contrast 1.0, balances 1.0, min_out 0 and max_out 65535.
module gamma_brightness_contrast_curve_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [gbc_pkg::IdxW-1:0]  cfg_index,
  input  logic [gbc_pkg::CfgW-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [gbc_pkg::PosW-1:0]  position,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gbc_pkg::OutW-1:0]  red,
  output logic [gbc_pkg::OutW-1:0]  green,
  output logic [gbc_pkg::OutW-1:0]  blue,
  output logic                      last_out
);
  import gbc_pkg::*;

  logic [GammaW-1:0] gamma;
  logic [BcW-1:0]    brightness;
  logic [BcW-1:0]    contrast;
  logic [BalW-1:0]   balance_red;
  logic [BalW-1:0]   balance_green;
  logic [BalW-1:0]   balance_blue;
  logic [OutW-1:0]   min_out;
  logic [OutW-1:0]   max_out;

  logic              en;
  gbc_tag_t          in_tag;
  logic              log_valid;
  logic [NegW-1:0]   neg;
  gbc_tag_t          log_tag;
  logic              div_valid;
  logic [DivW-1:0]   quo;
  gbc_tag_t          div_tag;
  logic              exp_valid;
  logic [PowW-1:0]   pow;
  gbc_tag_t          exp_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma         <= GammaW'(4096);
      brightness    <= BcW'(4096);
      contrast      <= BcW'(4096);
      balance_red   <= BalW'(16384);
      balance_green <= BalW'(16384);
      balance_blue  <= BalW'(16384);
      min_out       <= '0;
      max_out       <= '1;
    end else if (cfg_write) begin
      case (gbc_reg_t'(cfg_index))
        REG_GAMMA:      gamma         <= cfg_data[GammaW-1:0];
        REG_BRIGHTNESS: brightness    <= cfg_data[BcW-1:0];
        REG_CONTRAST:   contrast      <= cfg_data[BcW-1:0];
        REG_BAL_RED:    balance_red   <= cfg_data[BalW-1:0];
        REG_BAL_GREEN:  balance_green <= cfg_data[BalW-1:0];
        REG_BAL_BLUE:   balance_blue  <= cfg_data[BalW-1:0];
        REG_MIN_OUT:    min_out       <= cfg_data[OutW-1:0];
        REG_MAX_OUT:    max_out       <= cfg_data[OutW-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !out_valid || out_ready;
  assign in_ready    = en;
  assign in_tag.last = last_point;
  assign in_tag.zero = (position == '0);

  gbc_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .position  (position),
    .in_tag    (in_tag),
    .out_valid (log_valid),
    .neg       (neg),
    .out_tag   (log_tag)
  );

  gbc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .gamma     (gamma),
    .in_valid  (log_valid),
    .neg       (neg),
    .in_tag    (log_tag),
    .out_valid (div_valid),
    .quo       (quo),
    .out_tag   (div_tag)
  );

  gbc_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .quo       (quo),
    .in_tag    (div_tag),
    .out_valid (exp_valid),
    .pow       (pow),
    .out_tag   (exp_tag)
  );

  gbc_shape u_shape (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .brightness    (brightness),
    .contrast      (contrast),
    .balance_red   (balance_red),
    .balance_green (balance_green),
    .balance_blue  (balance_blue),
    .min_out       (min_out),
    .max_out       (max_out),
    .in_valid      (exp_valid),
    .pow           (pow),
    .in_tag        (exp_tag),
    .out_valid     (out_valid),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_out      (last_out)
  );

endmodule

### design/gbc_checker.sv
`include "assert_macros.svh"

module gbc_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [gbc_pkg::OutW-1:0] red,
  input logic [gbc_pkg::OutW-1:0] green,
  input logic [gbc_pkg::OutW-1:0] blue,
  input logic                     last_out
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(last_out))
  `ASSERT_SAME(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready)
  `ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !out_valid)

endmodule

bind gamma_brightness_contrast_curve_core gbc_checker u_gbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red       (red),
  .green     (green),
  .blue      (blue),
  .last_out  (last_out)
);

### tb/tb_gamma_brightness_contrast_curve_core.sv
module tb_gamma_brightness_contrast_curve_core;
  import gbc_pkg::*;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
  } curve_val_t;

  typedef struct {
    logic [15:0] pos;
    logic        last;
    logic        typed;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [15:0]     position = '0;
  logic            last_point = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [15:0]     red, green, blue;
  logic            last_out;

  logic [15:0] m_gamma, m_bal[3], m_min, m_max;
  logic [13:0] m_bright, m_contr;
  longint unsigned exp_fac[16];

  curve_val_t curve_queue[$];
  logic       calm = 1'b0;
  logic       cur_typed = 1'b0;
  curve_val_t cur_typed_val;
  int         errors = 0;
  int         points_sent = 0;
  int         results_seen = 0;
  int         cycle_count = 0;

  gamma_brightness_contrast_curve_core i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .position(position), .last_point(last_point), .out_valid(out_valid),
    .out_ready(out_ready), .red(red), .green(green), .blue(blue),
    .last_out(last_out)
  );

  always #4 clk = ~clk;

  function automatic logic busy_now();
    return !calm && ($urandom_range(99) < 29);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned pos_power(logic [15:0] pos);
    int k;
    longint unsigned m, frac, neg, q, n, r, g;
    if (pos == 0) return 0;
    g = (m_gamma == 0) ? 1 : m_gamma;
    k = 15;
    while (!pos[k]) k--;
    m = (longint'(pos) << (15 - k)) << 15;
    frac = 0;
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (16 - i));
      end
    end
    neg = (longint'(16 - k) << 16) - frac;
    q = (neg * 4096) / g;
    n = q >> 16;
    if (n >= 31) return 0;
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++)
      if (q[16 - i]) r = (r * exp_fac[i - 1]) >> 30;
    return r >> n;
  endfunction

  function automatic curve_val_t curve_point(logic [15:0] pos, logic last);
    curve_val_t cv;
    longint ct, br, mn, mx, c30, v16, x;
    logic [15:0] ch[3];
    ct = m_contr;
    br = m_bright;
    mn = m_min;
    mx = m_max;
    c30 = (((ct + 4096) * longint'(pos_power(pos))) >>> 13) + (br - ct) * 65536;
    v16 = ((mn <<< 30) + c30 * (mx - mn)) >>> 14;
    for (int i = 0; i < 3; i++) begin
      x = (v16 * longint'(m_bal[i]) + (64'sd1 <<< 29)) >>> 30;
      if (x < mn) x = mn;
      else if (x > mx) x = mx;
      ch[i] = x[15:0];
    end
    cv.red = ch[0];
    cv.green = ch[1];
    cv.blue = ch[2];
    cv.last = last;
    return cv;
  endfunction

  function automatic void apply_reg(gbc_reg_t idx, logic [15:0] d);
    case (idx)
      REG_GAMMA:      m_gamma = d;
      REG_BRIGHTNESS: m_bright = d[13:0];
      REG_CONTRAST:   m_contr = d[13:0];
      REG_BAL_RED:    m_bal[0] = d;
      REG_BAL_GREEN:  m_bal[1] = d;
      REG_BAL_BLUE:   m_bal[2] = d;
      REG_MIN_OUT:    m_min = d;
      REG_MAX_OUT:    m_max = d;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !busy_now();
    end
  end

  // Sampled at the falling edge, where everything has settled since the last
  // rising edge; a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    curve_val_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = cur_typed ? cur_typed_val : curve_point(position, last_point);
        want.last = last_point;
        curve_queue.push_back(want);
        points_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (curve_queue.size() == 0) begin
          $error("result transfer with no expectation pending");
          errors++;
        end else begin
          want = curve_queue.pop_front();
          if (red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red);
            errors++;
          end
          if (green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green);
            errors++;
          end
          if (blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue);
            errors++;
          end
          if (last_out !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, last_out);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_point(logic [15:0] p, logic l, logic typed, curve_val_t tv);
    logic ok;
    while (busy_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    position <= p;
    last_point <= l;
    cur_typed <= typed;
    cur_typed_val <= tv;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    cur_typed <= 1'b0;
    @(posedge clk);
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(gbc_reg_t idx, logic [15:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    apply_reg(idx, d);
  endtask

  task automatic write_all(logic [15:0] g, logic [15:0] b, logic [15:0] c,
                           logic [15:0] br, logic [15:0] bg, logic [15:0] bb,
                           logic [15:0] mn, logic [15:0] mx);
    drain();
    write_reg(REG_GAMMA, g);
    write_reg(REG_BRIGHTNESS, b);
    write_reg(REG_CONTRAST, c);
    write_reg(REG_BAL_RED, br);
    write_reg(REG_BAL_GREEN, bg);
    write_reg(REG_BAL_BLUE, bb);
    write_reg(REG_MIN_OUT, mn);
    write_reg(REG_MAX_OUT, mx);
    cfg_write <= 1'b0;
  endtask

  task automatic random_points(int count);
    logic [15:0] p;
    curve_val_t none;
    none = '{default: '0};
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0: p = 16'(1 << $urandom_range(15));
        1: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        2: p = 16'($urandom_range(15));
        default: p = 16'($urandom_range(16'hFFFF));
      endcase
      send_point(p, 1'($urandom_range(1)), 1'b0, none);
    end
  endtask

  stim_row_t directed[] = '{
    '{16'h0000, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0},
    '{16'h0000, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0},
    '{16'h0001, 1'b0, 1'b0, 0, 0, 0},
    '{16'h0002, 1'b1, 1'b0, 0, 0, 0},
    '{16'h0003, 1'b0, 1'b0, 0, 0, 0},
    '{16'h00FF, 1'b0, 1'b0, 0, 0, 0},
    '{16'h0100, 1'b1, 1'b0, 0, 0, 0},
    '{16'h1000, 1'b0, 1'b0, 0, 0, 0},
    '{16'h4000, 1'b0, 1'b0, 0, 0, 0},
    '{16'h5555, 1'b1, 1'b0, 0, 0, 0},
    '{16'h7FFF, 1'b0, 1'b0, 0, 0, 0},
    '{16'h8000, 1'b0, 1'b0, 0, 0, 0},
    '{16'hAAAA, 1'b1, 1'b0, 0, 0, 0},
    '{16'hC000, 1'b0, 1'b0, 0, 0, 0},
    '{16'hFFFE, 1'b0, 1'b0, 0, 0, 0},
    '{16'hFFFF, 1'b1, 1'b0, 0, 0, 0},
    '{16'h0000, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0}
  };

  initial begin
    curve_val_t tv;
    exp_fac[0] = root_floor(64'd1 << 59);
    for (int i = 1; i < 16; i++) exp_fac[i] = root_floor(exp_fac[i - 1] << 30);
    m_gamma = 4096;
    m_bright = 4096;
    m_contr = 4096;
    m_bal = '{16384, 16384, 16384};
    m_min = 0;
    m_max = 65535;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      tv = '{directed[i].red, directed[i].green, directed[i].blue, directed[i].last};
      send_point(directed[i].pos, directed[i].last, directed[i].typed, tv);
    end
    random_points(40);
    drain();
    calm = 1'b1;
    random_points(60);
    calm = 1'b0;

    write_all(16'd1, 16'd16383, 16'd0, 16'hFFFF, 16'd0, 16'd32768, 16'd0, 16'hFFFF);
    random_points(70);
    write_all(16'hFFFF, 16'd0, 16'd16383, 16'd16384, 16'd20000, 16'd9000,
              16'd1000, 16'd60000);
    random_points(70);
    write_all(16'd0, 16'hFFFF, 16'd3000, 16'd16384, 16'd16384, 16'd16384,
              16'd50000, 16'd10000);
    random_points(60);
    write_all(16'd8192, 16'd8192, 16'd8192, 16'd30000, 16'd16384, 16'd5000,
              16'hFFFF, 16'hFFFF);
    random_points(40);
    for (int ph = 0; ph < 4; ph++) begin
      write_all(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                16'($urandom_range(16'h3FFF)),
                16'hC000 + 16'($urandom_range(16'h3FFF)));
      random_points(60);
    end

    drain();
    $display("Sent %0d curve points and checked %0d results over nine register settings,",
             points_sent, results_seen);
    $display("including gamma zero, one and maximum and an inverted output range.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
